// ----- rtl/core/segi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_pkg
// Types, widths and constants shared by the segment intersection block.
// ----------------------------------------------------------------------------
package segi_pkg;

	localparam int IN_BITS      = 16;
	localparam int OUT_BITS     = 24;
	localparam int COORD_BITS   = 16;
	localparam int FRAC_BITS    = 8;

	// differences, products and cross products
	localparam int RW = COORD_BITS + 1;
	localparam int PW = 2 * RW;
	localparam int DW = PW + 1;
	// magnitude of the direction cross product
	localparam int MW = 2 * COORD_BITS + 2;
	// weighted sum a*(d-t) + b*t
	localparam int SW = COORD_BITS + MW + 2;
	// dividend after the fraction shift
	localparam int NW = SW + FRAC_BITS;
	// quotient bits, one divider stage per bit
	localparam int QW = COORD_BITS + FRAC_BITS;
	localparam int EW = ((QW > OUT_BITS) ? QW : OUT_BITS) + 1;

	localparam int FRONT_STAGES = 7;
	localparam int FIFO_DEPTH   = 8;
	localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
	localparam int LATENCY      = FRONT_STAGES + QW + 2;

	localparam logic [EW-1:0] OUT_MAXPOS = EW'((2 ** (OUT_BITS - 1)) - 1);
	localparam logic [EW-1:0] OUT_MAXNEG = EW'(2 ** (OUT_BITS - 1));

	typedef struct packed {
		logic signed [IN_BITS-1:0] first_start_x;
		logic signed [IN_BITS-1:0] first_start_y;
		logic signed [IN_BITS-1:0] first_end_x;
		logic signed [IN_BITS-1:0] first_end_y;
		logic signed [IN_BITS-1:0] second_start_x;
		logic signed [IN_BITS-1:0] second_start_y;
		logic signed [IN_BITS-1:0] second_end_x;
		logic signed [IN_BITS-1:0] second_end_y;
	} seg_in_t;

	typedef struct packed {
		logic                       hit;
		logic signed [OUT_BITS-1:0] cross_x;
		logic signed [OUT_BITS-1:0] cross_y;
	} seg_out_t;

	// classified item handed from front to back
	typedef struct packed {
		logic          hit;
		logic [MW-1:0] d;
		logic [NW-1:0] num_x;
		logic [NW-1:0] num_y;
		logic          neg_x;
		logic          neg_y;
	} job_t;

endpackage

// ----- rtl/core/segi_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_front
// Cross products, hit classification and dividend build, seven stages.
// ----------------------------------------------------------------------------
module segi_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  segi_pkg::seg_in_t item,
	output logic            push,
	output segi_pkg::job_t  job
);
	import segi_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic signed [RW-1:0] rx_s1, ry_s1, sx_s1, sy_s1, wx_s1, wy_s1;
	logic signed [COORD_BITS-1:0] p0x_s1, p1x_s1, p0y_s1, p1y_s1;
	logic signed [COORD_BITS-1:0] p0x_s2, p1x_s2, p0y_s2, p1y_s2;
	logic signed [COORD_BITS-1:0] p0x_s3, p1x_s3, p0y_s3, p1y_s3;
	logic signed [COORD_BITS-1:0] p0x_s4, p1x_s4, p0y_s4, p1y_s4;
	logic signed [COORD_BITS-1:0] p0x_s5, p1x_s5, p0y_s5, p1y_s5;

	logic signed [PW-1:0] m_rs_s2, m_rys_s2, m_ws_s2, m_wys_s2, m_wr_s2, m_wyr_s2;
	logic signed [DW-1:0] d_s3, tn_s3, un_s3;
	logic signed [DW-1:0] d_s4, tn_s4, un_s4;
	logic                 hit_s5, hit_s6, hit_s7;
	logic [MW-1:0]        dmt_s5, t_s5, d_s5, d_s6;
	logic signed [SW-1:0] ax_s6, bx_s6, ay_s6, by_s6;
	logic [NW-1:0]        num_x_s7, num_y_s7;
	logic                 neg_x_s7, neg_y_s7;
	logic [MW-1:0]        d_s7;

	logic signed [COORD_BITS-1:0] p0x, p1x, p0y, p1y, q0x, q1x, q0y, q1y;
	logic signed [SW-1:0] sum_x, sum_y;

	function automatic logic signed [COORD_BITS-1:0] sext(input logic [IN_BITS-1:0] v);
		return $signed(v[COORD_BITS-1:0]);
	endfunction

	assign p0x = sext(item.first_start_x);
	assign p0y = sext(item.first_start_y);
	assign p1x = sext(item.first_end_x);
	assign p1y = sext(item.first_end_y);
	assign q0x = sext(item.second_start_x);
	assign q0y = sext(item.second_start_y);
	assign q1x = sext(item.second_end_x);
	assign q1y = sext(item.second_end_y);

	assign sum_x = ax_s6 + bx_s6;
	assign sum_y = ay_s6 + by_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		// s1: direction and offset vectors
		rx_s1  <= RW'(p1x) - RW'(p0x);
		ry_s1  <= RW'(p1y) - RW'(p0y);
		sx_s1  <= RW'(q1x) - RW'(q0x);
		sy_s1  <= RW'(q1y) - RW'(q0y);
		wx_s1  <= RW'(q0x) - RW'(p0x);
		wy_s1  <= RW'(q0y) - RW'(p0y);
		p0x_s1 <= p0x;
		p1x_s1 <= p1x;
		p0y_s1 <= p0y;
		p1y_s1 <= p1y;

		// s2: products
		m_rs_s2  <= PW'(rx_s1) * PW'(sy_s1);
		m_rys_s2 <= PW'(ry_s1) * PW'(sx_s1);
		m_ws_s2  <= PW'(wx_s1) * PW'(sy_s1);
		m_wys_s2 <= PW'(wy_s1) * PW'(sx_s1);
		m_wr_s2  <= PW'(wx_s1) * PW'(ry_s1);
		m_wyr_s2 <= PW'(wy_s1) * PW'(rx_s1);
		{p0x_s2, p1x_s2, p0y_s2, p1y_s2} <= {p0x_s1, p1x_s1, p0y_s1, p1y_s1};

		// s3: cross products
		d_s3  <= DW'(m_rs_s2) - DW'(m_rys_s2);
		tn_s3 <= DW'(m_ws_s2) - DW'(m_wys_s2);
		un_s3 <= DW'(m_wr_s2) - DW'(m_wyr_s2);
		{p0x_s3, p1x_s3, p0y_s3, p1y_s3} <= {p0x_s2, p1x_s2, p0y_s2, p1y_s2};

		// s4: make the denominator non-negative
		if (d_s3 < 0) begin
			d_s4  <= -d_s3;
			tn_s4 <= -tn_s3;
			un_s4 <= -un_s3;
		end else begin
			d_s4  <= d_s3;
			tn_s4 <= tn_s3;
			un_s4 <= un_s3;
		end
		{p0x_s4, p1x_s4, p0y_s4, p1y_s4} <= {p0x_s3, p1x_s3, p0y_s3, p1y_s3};

		// s5: both parameters inside [0,1]
		hit_s5 <= (d_s4 != '0) && (tn_s4 >= 0) && (tn_s4 <= d_s4)
			&& (un_s4 >= 0) && (un_s4 <= d_s4);
		dmt_s5 <= MW'(d_s4 - tn_s4);
		t_s5   <= tn_s4[MW-1:0];
		d_s5   <= d_s4[MW-1:0];
		{p0x_s5, p1x_s5, p0y_s5, p1y_s5} <= {p0x_s4, p1x_s4, p0y_s4, p1y_s4};

		// s6: weighted endpoints
		ax_s6  <= SW'(p0x_s5) * SW'($signed({1'b0, dmt_s5}));
		bx_s6  <= SW'(p1x_s5) * SW'($signed({1'b0, t_s5}));
		ay_s6  <= SW'(p0y_s5) * SW'($signed({1'b0, dmt_s5}));
		by_s6  <= SW'(p1y_s5) * SW'($signed({1'b0, t_s5}));
		hit_s6 <= hit_s5;
		d_s6   <= d_s5;

		// s7: sign and magnitude of the dividend
		neg_x_s7 <= sum_x[SW-1];
		neg_y_s7 <= sum_y[SW-1];
		num_x_s7 <= NW'(sum_x[SW-1] ? SW'(-sum_x) : SW'(sum_x)) << FRAC_BITS;
		num_y_s7 <= NW'(sum_y[SW-1] ? SW'(-sum_y) : SW'(sum_y)) << FRAC_BITS;
		hit_s7   <= hit_s6;
		d_s7     <= d_s6;
	end

	assign push      = v_s7;
	assign job.hit   = hit_s7;
	assign job.d     = d_s7;
	assign job.num_x = num_x_s7;
	assign job.num_y = num_y_s7;
	assign job.neg_x = neg_x_s7;
	assign job.neg_y = neg_y_s7;

endmodule

// ----- rtl/core/segi_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_queue
// Short item queue between the classifier front and the divider back.
// ----------------------------------------------------------------------------
module segi_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  segi_pkg::job_t wr_job,
	output logic           pop,
	output segi_pkg::job_t rd_job,
	output logic           full_soon
);
	import segi_pkg::*;

	job_t               mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	// back end never stalls, so a stored item leaves at once
	assign pop    = (count_q != '0);
	assign rd_job = mem[rd_ptr_q];
	// room for every item that may still be in the front
	assign full_soon = (count_q > (FIFO_AW+1)'(FIFO_DEPTH - FRONT_STAGES));

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
		end
	end

endmodule

// ----- rtl/core/segi_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_back
// Pipelined restoring divider, one quotient bit per stage, two lanes.
// ----------------------------------------------------------------------------
module segi_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop,
	input  segi_pkg::job_t     job,
	output logic               done,
	output segi_pkg::seg_out_t result
);
	import segi_pkg::*;

	typedef struct packed {
		logic [MW-1:0] rem;
		logic [QW-1:0] num;
		logic [QW-1:0] q;
		logic          neg;
	} lane_t;

	lane_t         x_s   [QW];
	lane_t         y_s   [QW];
	logic [MW-1:0] d_s   [QW];
	logic          hit_s [QW];
	logic          v_s   [QW];

	lane_t    init_x, init_y;
	logic     done_q;
	seg_out_t result_q;

	function automatic lane_t div_step(input lane_t l, input logic [MW-1:0] dv);
		logic [MW:0] trial;
		lane_t       r;
		trial = {l.rem, l.num[QW-1]};
		r     = l;
		if (trial >= {1'b0, dv}) begin
			r.rem = MW'(trial - {1'b0, dv});
			r.q   = {l.q[QW-2:0], 1'b1};
		end else begin
			r.rem = trial[MW-1:0];
			r.q   = {l.q[QW-2:0], 1'b0};
		end
		r.num = {l.num[QW-2:0], 1'b0};
		return r;
	endfunction

	function automatic logic [OUT_BITS-1:0] finish(input lane_t l);
		logic [EW-1:0] qe;
		qe = EW'(l.q);
		if (!l.neg && (qe > OUT_MAXPOS)) begin
			qe = OUT_MAXPOS;
		end
		if (l.neg && (qe > OUT_MAXNEG)) begin
			qe = OUT_MAXNEG;
		end
		if (l.neg) begin
			qe = -qe;
		end
		return qe[OUT_BITS-1:0];
	endfunction

	assign init_x = '{rem: job.num_x[QW+MW-1:QW], num: job.num_x[QW-1:0],
		q: '0, neg: job.neg_x};
	assign init_y = '{rem: job.num_y[QW+MW-1:QW], num: job.num_y[QW-1:0],
		q: '0, neg: job.neg_y};

	for (genvar i = 0; i < QW; i++) begin : g_stage
		if (i == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[i] <= 1'b0;
				end else begin
					v_s[i] <= pop;
				end
			end
			always_ff @(posedge clk) begin
				x_s[i]   <= div_step(init_x, job.d);
				y_s[i]   <= div_step(init_y, job.d);
				d_s[i]   <= job.d;
				hit_s[i] <= job.hit;
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[i] <= 1'b0;
				end else begin
					v_s[i] <= v_s[i-1];
				end
			end
			always_ff @(posedge clk) begin
				x_s[i]   <= div_step(x_s[i-1], d_s[i-1]);
				y_s[i]   <= div_step(y_s[i-1], d_s[i-1]);
				d_s[i]   <= d_s[i-1];
				hit_s[i] <= hit_s[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		result_q.hit <= hit_s[QW-1];
		if (hit_s[QW-1]) begin
			result_q.cross_x <= finish(x_s[QW-1]);
			result_q.cross_y <= finish(y_s[QW-1]);
		end else begin
			result_q.cross_x <= '0;
			result_q.cross_y <= '0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- rtl/core/segment_intersection.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection
// Exact 2D segment intersection test with fixed point crossing point.
// ----------------------------------------------------------------------------
// An item is two segments given as eight signed 16-bit endpoint coordinates
// on item; it is taken at a rising edge with start high and busy low.
// Each item gives one result on result (hit, cross_x, cross_y), shown for
// exactly one cycle with done high; results come out in item order.
// The receiver cannot stall the block and nothing downstream waits.
// An item passes seven front stages (cross products, classification and
// dividend), the queue, one divider stage per quotient bit and an output stage.
// Throughput is one item per cycle; the divider is fully pipelined, so the
// queue never fills and busy stays low in normal use.
// Parallel, collinear or degenerate segments and misses give hit low with
// both coordinates zero. The point is truncated toward zero and saturated
// to 24 bits.
// Reset empties the front pipeline, the queue and the divider; items in
// flight at reset are dropped and no result is shown for them.
// ----------------------------------------------------------------------------
module segment_intersection (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  segi_pkg::seg_in_t  item,
	output logic               done,
	output segi_pkg::seg_out_t result
);
	import segi_pkg::*;

	logic accept;
	logic push, pop, full_soon;
	job_t wr_job, rd_job;

	assign busy   = full_soon;
	assign accept = start && !busy;

	segi_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.push   (push),
		.job    (wr_job)
	);

	segi_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_job    (wr_job),
		.pop       (pop),
		.rd_job    (rd_job),
		.full_soon (full_soon)
	);

	segi_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.pop    (pop),
		.job    (rd_job),
		.done   (done),
		.result (result)
	);

endmodule

// ----- rtl/core/segi_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_checker
// Port level checks of result timing and miss encoding.
// ----------------------------------------------------------------------------
module segi_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input segi_pkg::seg_out_t result
);
	import segi_pkg::*;

	// every item comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("item result missing after fixed latency");

	// no result without an item taken that long ago
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching item");

	// a miss reports a zero point
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit) |-> (result.cross_x == '0 && result.cross_y == '0))
		else $error("miss with nonzero point");

endmodule

bind segment_intersection segi_checker u_segi_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams segment pairs into segment_intersection and checks every result,
// in order, against an exact cross product and long division predictor.
// ----------------------------------------------------------------------------

class seg_scoreboard;
	segi_pkg::seg_out_t pending[$];
	int errors;

	// exact 2d segment test, point truncated toward zero and saturated
	function segi_pkg::seg_out_t predict(segi_pkg::seg_in_t it);
		segi_pkg::seg_out_t o;
		longint p0x, p0y, p1x, p1y, q0x, q0y, q1x, q1y;
		longint rx, ry, sx, sy, wx, wy, d, tn, un;
		p0x = it.first_start_x;  p0y = it.first_start_y;
		p1x = it.first_end_x;    p1y = it.first_end_y;
		q0x = it.second_start_x; q0y = it.second_start_y;
		q1x = it.second_end_x;   q1y = it.second_end_y;
		rx = p1x - p0x; ry = p1y - p0y;
		sx = q1x - q0x; sy = q1y - q0y;
		wx = q0x - p0x; wy = q0y - p0y;
		d  = rx * sy - ry * sx;
		tn = wx * sy - wy * sx;
		un = wx * ry - wy * rx;
		o = '0;
		if (d == 0)
			return o;
		if (d < 0) begin
			d = -d; tn = -tn; un = -un;
		end
		if (tn < 0 || tn > d || un < 0 || un > d)
			return o;
		o.hit = 1'b1;
		o.cross_x = lerp_fixed(p0x, p1x, tn, d);
		o.cross_y = lerp_fixed(p0y, p1y, tn, d);
		return o;
	endfunction

	function logic [23:0] lerp_fixed(longint a, longint b, longint t, longint d);
		logic signed [127:0] num, q, mag;
		num = (128'(signed'(a)) * 128'(signed'(d - t)) + 128'(signed'(b)) * 128'(t))
			<<< segi_pkg::FRAC_BITS;
		mag = (num < 0) ? -num : num;
		q = mag / 128'(d);
		if (num >= 0 && q > 128'sh7FFFFF)
			q = 128'sh7FFFFF;
		if (num < 0 && q > 128'sh800000)
			q = 128'sh800000;
		if (num < 0)
			q = -q;
		return q[23:0];
	endfunction

	function void note_item(segi_pkg::seg_in_t it);
		pending.push_back(predict(it));
	endfunction

	function void check_result(segi_pkg::seg_out_t got);
		segi_pkg::seg_out_t exp_r;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			errors++;
			return;
		end
		exp_r = pending.pop_front();
		if (got.hit !== exp_r.hit || got.cross_x !== exp_r.cross_x
				|| got.cross_y !== exp_r.cross_y) begin
			$display("%0t: mismatch expected hit=%0b x=%h y=%h actual hit=%0b x=%h y=%h",
				$time, exp_r.hit, exp_r.cross_x, exp_r.cross_y,
				got.hit, got.cross_x, got.cross_y);
			errors++;
		end
	endfunction
endclass

module tb;
	import segi_pkg::*;

	localparam int WATCHDOG = 2000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	seg_in_t item;
	logic done;
	seg_out_t result;

	seg_scoreboard sb;
	int idle_cycles;
	bit timed_out;

	segment_intersection u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .done(done), .result(result)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(result);
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG && !timed_out) begin
				timed_out = 1;
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// optionally drop start for a gap, then hold the item until taken
	task automatic send_item(seg_in_t it);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		sb.note_item(it);
	endtask

	function automatic logic [15:0] rnd_coord(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 64) - 32);
			default: return ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
		endcase
	endfunction

	function automatic seg_in_t seg(int ax, int ay, int bx, int by,
			int cx, int cy, int dx, int dy);
		seg_in_t s;
		s.first_start_x = 16'(ax);  s.first_start_y = 16'(ay);
		s.first_end_x = 16'(bx);    s.first_end_y = 16'(by);
		s.second_start_x = 16'(cx); s.second_start_y = 16'(cy);
		s.second_end_x = 16'(dx);   s.second_end_y = 16'(dy);
		return s;
	endfunction

	initial begin
		seg_in_t it;
		int mode;
		sb = new();
		idle_cycles = 0;
		timed_out = 0;
		start = 0;
		item = '0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// plain crossing, parallel, collinear, zero length, endpoint touch, miss
		send_item(seg(0, 0, 10, 10, 0, 10, 10, 0));
		send_item(seg(0, 0, 10, 0, 0, 5, 10, 5));
		send_item(seg(0, 0, 10, 0, 5, 0, 20, 0));
		send_item(seg(3, 3, 3, 3, 0, 0, 10, 10));
		send_item(seg(0, 0, 10, 0, 10, 0, 10, 10));
		send_item(seg(0, 0, 10, 0, 11, -5, 11, 5));
		send_item(seg(0, 0, 3, 1, 1, 0, 0, 1));
		send_item(seg(-1, -1, 2, 3, -3, 2, 4, -1));
		// extremes of the coordinate range
		send_item(seg(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
		send_item(seg(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
		send_item(seg(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
		send_item(seg(-32768, -32768, -32768, 32767, -32768, 32767, 32767, 32767));
		send_item(seg(-32768, -32768, 32767, -32767, 32767, -32768, -32768, -32767));
		send_item(seg(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
		send_item(seg(-32768, -32768, -32768, -32768, 0, 0, 1, 1));
		send_item(seg(0, 0, 1, 32767, 1, 0, 0, 32767));

		for (int n = 0; n < 900; n++) begin
			mode = $urandom_range(0, 9);
			if (mode < 5) begin
				// built to cross: both segments pass through a shared point
				int cx, cy, ax, ay, bx, by;
				cx = $urandom_range(0, 40000) - 20000;
				cy = $urandom_range(0, 40000) - 20000;
				ax = $urandom_range(0, 24000) - 12000;
				ay = $urandom_range(0, 24000) - 12000;
				bx = $urandom_range(0, 24000) - 12000;
				by = $urandom_range(0, 24000) - 12000;
				it = seg(cx - ax, cy - ay, cx + ax / int'($urandom_range(1, 3)),
					cy + ay / int'($urandom_range(1, 3)),
					cx - bx, cy - by, cx + bx, cy + by);
			end else begin
				it = seg(rnd_coord(mode % 3), rnd_coord(mode % 3), rnd_coord(mode % 3),
					rnd_coord(mode % 3), rnd_coord(mode % 3), rnd_coord(mode % 3),
					rnd_coord(mode % 3), rnd_coord(mode % 3));
				if (mode == 9)
					it.second_end_x = it.second_start_x + (it.first_end_x - it.first_start_x);
			end
			send_item(it);
		end
		start <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
